>>> design/bfa_pkg.sv
package bfa_pkg;

	localparam int ALPHABET   = 32;
	localparam int SYM_W      = 5;
	localparam int IDX_W      = 2 * SYM_W;
	localparam int HIST_DEPTH = ALPHABET * ALPHABET;
	localparam int COUNT_BITS = 16;
	localparam int EPOCH_W    = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [EPOCH_W-1:0]    epoch_t;

	// one classified pair between front and back
	typedef struct packed {
		logic [IDX_W-1:0] idx;     // {previous symbol, current symbol}
		logic             pair_ok; // a previous symbol exists
		logic             last;    // closes the string
	} pair_item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic       avail;
		pair_item_t item;
	} queue_head_t;

	// histogram word: epoch tag and count
	typedef struct packed {
		epoch_t tag;
		count_t cnt;
	} hist_word_t;

endpackage

>>> design/bfa_front.sv
module bfa_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [bfa_pkg::SYM_W-1:0] symbol,
	input  logic                    last,
	input  logic                    q_full,
	input  logic                    clearing,
	output logic                    push,
	output bfa_pkg::pair_item_t     push_item
);
	import bfa_pkg::*;

	logic [SYM_W-1:0] prev_q;
	logic             have_prev_q;

	assign in_stall = q_full || clearing;
	assign push     = in_valid && !in_stall;

	// symbol is already within the alphabet (5 bits, 32 symbols)
	assign push_item.idx     = {prev_q, symbol};
	assign push_item.pair_ok = have_prev_q;
	assign push_item.last    = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (push) begin
			if (last) begin
				prev_q      <= '0;
				have_prev_q <= 1'b0;
			end else begin
				prev_q      <= symbol;
				have_prev_q <= 1'b1;
			end
		end
	end

endmodule

>>> design/bfa_fifo.sv
module bfa_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bfa_pkg::pair_item_t  push_item,
	output logic                 full,
	input  logic                 pop,
	output bfa_pkg::queue_head_t head
);
	import bfa_pkg::*;

	pair_item_t            slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head.avail = (cnt_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head.avail)
		else $error("fifo pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("fifo push while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("fifo count did not follow push");

endmodule

>>> design/bfa_back.sv
module bfa_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bfa_pkg::queue_head_t      q_head,
	output logic                      pop,
	output logic                      clearing,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bfa_pkg::SYM_W-1:0] pair_first,
	output logic [bfa_pkg::SYM_W-1:0] pair_second,
	output logic [15:0]               pair_count,
	output logic                      pair_found
);
	import bfa_pkg::*;

	localparam count_t COUNT_MAX = '1;
	localparam epoch_t EPOCH_MAX = '1;

	hist_word_t hist_mem [HIST_DEPTH];
	hist_word_t rd_q;

	// read-modify-write stage
	logic       valid_s1;
	pair_item_t item_s1;
	logic       s1_done;

	// last write, forwarded to the next read of the same pair
	logic             fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	count_t           fwd_cnt_q;

	logic [SYM_W-1:0] best_first_q;
	logic [SYM_W-1:0] best_second_q;
	count_t           best_tally_q;

	epoch_t           epoch_q;
	logic             clear_q;
	logic [IDX_W-1:0] clr_ptr_q;

	logic             out_valid_q;
	logic [SYM_W-1:0] out_first_q;
	logic [SYM_W-1:0] out_second_q;
	count_t           out_count_q;
	logic             out_found_q;

	logic             out_free;
	logic             wrap_hold;
	count_t           cur_cnt;
	count_t           new_cnt;
	logic             better;
	logic [SYM_W-1:0] nb_first;
	logic [SYM_W-1:0] nb_second;
	count_t           nb_tally;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	hist_word_t       mem_wd;

	assign out_free  = !out_valid_q || !out_stall;
	assign s1_done   = valid_s1 && (!item_s1.last || out_free);
	// a string end that wraps the epoch is followed by a clearing pass
	assign wrap_hold = valid_s1 && item_s1.last && (epoch_q == EPOCH_MAX);
	assign pop       = q_head.avail && !clear_q && !wrap_hold && (!valid_s1 || s1_done);
	assign clearing  = clear_q;

	always_comb begin
		if (fwd_valid_q && (fwd_idx_q == item_s1.idx)) begin
			cur_cnt = fwd_cnt_q;
		end else if (rd_q.tag == epoch_q) begin
			cur_cnt = rd_q.cnt;
		end else begin
			cur_cnt = '0;
		end
		new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
		better  = item_s1.pair_ok && (new_cnt > best_tally_q);
		if (better) begin
			nb_first  = item_s1.idx[IDX_W-1:SYM_W];
			nb_second = item_s1.idx[SYM_W-1:0];
			nb_tally  = new_cnt;
		end else begin
			nb_first  = best_first_q;
			nb_second = best_second_q;
			nb_tally  = best_tally_q;
		end
	end

	always_comb begin
		if (clear_q) begin
			mem_we = 1'b1;
			mem_wa = clr_ptr_q;
			mem_wd = '0;
		end else begin
			mem_we     = s1_done && item_s1.pair_ok;
			mem_wa     = item_s1.idx;
			mem_wd.tag = epoch_q;
			mem_wd.cnt = new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rd_q    <= hist_mem[q_head.item.idx];
			item_s1 <= q_head.item;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && item_s1.pair_ok) begin
			fwd_idx_q <= item_s1.idx;
			fwd_cnt_q <= new_cnt;
		end
		if (s1_done && item_s1.last) begin
			out_first_q  <= nb_first;
			out_second_q <= nb_second;
			out_count_q  <= nb_tally;
			out_found_q  <= (nb_tally != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			fwd_valid_q   <= 1'b0;
			best_first_q  <= '0;
			best_second_q <= '0;
			best_tally_q  <= '0;
			epoch_q       <= '0;
			clear_q       <= 1'b1;
			clr_ptr_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end

			if (clear_q) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
				if (clr_ptr_q == IDX_W'(HIST_DEPTH - 1)) begin
					clear_q <= 1'b0;
				end
			end

			if (s1_done) begin
				if (item_s1.last) begin
					fwd_valid_q   <= 1'b0;
					best_first_q  <= '0;
					best_second_q <= '0;
					best_tally_q  <= '0;
					epoch_q       <= epoch_q + 1'b1;
					if (epoch_q == EPOCH_MAX) begin
						clear_q <= 1'b1;
					end
				end else begin
					if (item_s1.pair_ok) begin
						fwd_valid_q <= 1'b1;
					end
					best_first_q  <= nb_first;
					best_second_q <= nb_second;
					best_tally_q  <= nb_tally;
				end
			end

			if (s1_done && item_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pair_first  = out_first_q;
	assign pair_second = out_second_q;
	assign pair_count  = out_count_q[15:0];
	assign pair_found  = out_found_q;

	assert property (@(posedge clk) disable iff (!arst_n) clear_q |-> !pop && !valid_s1)
		else $error("histogram access during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && item_s1.last) |=> (best_tally_q == '0) && !fwd_valid_q)
		else $error("string state not cleared at string end");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && item_s1.last && (epoch_q == EPOCH_MAX)) |=> clear_q)
		else $error("epoch wrap without clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_done) |=> valid_s1 && $stable(item_s1))
		else $error("held pair lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && item_s1.last) |-> out_free)
		else $error("result overwrote a pending word");

endmodule

>>> design/bigram_frequency_argmax.sv
// Path: an accepted word goes through a queue entry, then the histogram
// read-modify-write stage, which at a string end loads the output register.
// Throughput: one word per cycle when no full queue, clearing pass or held result stalls
// it, set by one histogram read and one write-back per cycle, with previous-count forwarding.
// Reset (arst_n low, asynchronous): all control state cleared, then a clearing pass over
// all 1024 histogram words with input stalled; the same pass follows every 256th string.
module bigram_frequency_argmax (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bfa_pkg::SYM_W-1:0] symbol,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bfa_pkg::SYM_W-1:0] pair_first,
	output logic [bfa_pkg::SYM_W-1:0] pair_second,
	output logic [15:0]               pair_count,
	output logic                      pair_found
);
	import bfa_pkg::*;

	// Front: tracks the previous symbol and forms the pair index per word.
	// Queue: four entries, decouples input stalls from the histogram pipe.
	// Back: histogram RMW (epoch-tagged words, so a string end clears nothing unless
	//       it wraps the epoch), running best pair, output register.

	logic        q_full;
	logic        clearing;
	logic        push;
	pair_item_t  push_item;
	logic        pop;
	queue_head_t q_head;

	bfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.symbol    (symbol),
		.last      (last),
		.q_full    (q_full),
		.clearing  (clearing),
		.push      (push),
		.push_item (push_item)
	);

	bfa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head)
	);

	// Back end holds off popping while the epoch-wrapping string end drains,
	// so no read slips in ahead of the clearing pass.
	bfa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_head      (q_head),
		.pop         (pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pair_first  (pair_first),
		.pair_second (pair_second),
		.pair_count  (pair_count),
		.pair_found  (pair_found)
	);

endmodule

>>> tb/sv/tb_bigram_frequency_argmax.sv
module tb_bigram_frequency_argmax;
	timeunit 1ns;
	timeprecision 1ps;

	import bfa_pkg::*;

	// Run limit in clock cycles, set above the slowest correct run: every word
	// with the longest input gap and ending a string whose result is held off by
	// the longest stall, plus the histogram clearing passes after reset and after
	// every 256th string.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_WORDS = 1830;
	localparam int unsigned MAX_REPORTS = 10;
	localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_BITS) - 1;

	// one input word waiting in the driver queue; gap = idle cycles before it
	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             fin;
		int unsigned      gap;
	} sym_word_t;

	// one predicted result word
	typedef struct {
		logic [SYM_W-1:0] first;
		logic [SYM_W-1:0] second;
		logic [15:0]      count;
		logic             found;
	} bigram_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [SYM_W-1:0] symbol = '0;
	logic             last = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [SYM_W-1:0] pair_first;
	logic [SYM_W-1:0] pair_second;
	logic [15:0]      pair_count;
	logic             pair_found;

	sym_word_t   symbol_queue[$];
	bigram_t     bigram_queue[$];
	int unsigned words_total = 0;
	int unsigned words_taken = 0;
	int unsigned n_bad = 0;
	int unsigned cycle_count = 0;

	// predictor state, mirrors the block's string state
	int unsigned      pair_tally[HIST_DEPTH];
	logic [SYM_W-1:0] prev_sym = '0;
	bit               prev_ok = 1'b0;
	logic [SYM_W-1:0] lead_first = '0;
	logic [SYM_W-1:0] lead_second = '0;
	int unsigned      lead_tally = 0;

	// output-side stall pattern state
	int unsigned stall_left = 0;
	int unsigned phase_left = 0;
	bit          rx_calm = 1'b0;

	bigram_frequency_argmax i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pair_first (pair_first),
		.pair_second(pair_second),
		.pair_count (pair_count),
		.pair_found (pair_found)
	);

	initial forever #2 clk = ~clk;

	// reset once, released on a rising edge
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// idle length: mostly none, often short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Feeds one accepted word into the predicted histogram. Returns 1 when the
	// word closes the string, with the predicted result in res.
	function automatic bit count_bigram(input logic [SYM_W-1:0] sym, input logic fin,
			output bigram_t res);
		int unsigned s;
		int unsigned slot;
		int unsigned c;
		s = sym % ALPHABET;
		if (prev_ok) begin
			slot = prev_sym * ALPHABET + s;
			c = pair_tally[slot];
			if (c < TALLY_MAX)
				c++;
			pair_tally[slot] = c;
			// strictly greater: first pair to reach the top count keeps the lead
			if (c > lead_tally) begin
				lead_tally = c;
				lead_first = prev_sym;
				lead_second = s[SYM_W-1:0];
			end
		end
		prev_sym = s[SYM_W-1:0];
		prev_ok = 1'b1;
		if (!fin)
			return 1'b0;
		if (lead_tally > 0) begin
			res.first = lead_first;
			res.second = lead_second;
			res.count = lead_tally[15:0];
			res.found = 1'b1;
		end else begin
			res = '{default: '0};
		end
		// string over: clear everything
		foreach (pair_tally[k])
			pair_tally[k] = 0;
		prev_sym = '0;
		prev_ok = 1'b0;
		lead_first = '0;
		lead_second = '0;
		lead_tally = 0;
		return 1'b1;
	endfunction

	// calm words go out with no idle cycle ahead of them
	task automatic push_word(input logic [SYM_W-1:0] sym, input logic fin, input bit calm);
		sym_word_t w;
		w.sym = sym;
		w.fin = fin;
		w.gap = calm ? 0 : pick_gap();
		symbol_queue.insert(symbol_queue.size(), w);
		words_total++;
	endtask

	task automatic note_mismatch(input string what, input bigram_t want, input bigram_t got);
		n_bad++;
		if (n_bad <= MAX_REPORTS) begin
			$display("mismatch (%s): expected first=%0d second=%0d count=%0d found=%0b",
				what, want.first, want.second, want.count, want.found);
			$display("    got first=%0d second=%0d count=%0d found=%0b",
				got.first, got.second, got.count, got.found);
		end
	endtask

	// Input driver: one word on the bus at a time, held while stalled. A new
	// word (or an idle cycle from its gap) is taken only once the bus is free,
	// i.e. nothing valid or the current word accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		bigram_t res;
		sym_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			symbol <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				words_taken++;
				if (count_bigram(symbol, last, res))
					bigram_queue.insert(bigram_queue.size(), res);
			end
			if (!in_valid || !in_stall) begin
				if (symbol_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else if (symbol_queue[0].gap != 0) begin
					symbol_queue[0].gap = symbol_queue[0].gap - 1;
					in_valid <= 1'b0;
				end else begin
					w = symbol_queue.pop_front();
					symbol <= w.sym;
					last <= w.fin;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// Output monitor: checks each accepted result word against the oldest
	// prediction, then drives the stall pattern for the next cycle. Phases of
	// random length switch between random stalling and no stalling at all.
	always @(posedge clk or negedge arst_n) begin
		bigram_t want;
		bigram_t got;
		int unsigned g;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.first = pair_first;
				got.second = pair_second;
				got.count = pair_count;
				got.found = pair_found;
				if (bigram_queue.size() == 0) begin
					note_mismatch("no result pending", '{default: '0}, got);
				end else begin
					want = bigram_queue.pop_front();
					if (got.first !== want.first || got.second !== want.second ||
						got.count !== want.count || got.found !== want.found)
						note_mismatch("field", want, got);
				end
			end
			if (phase_left == 0) begin
				rx_calm = ($urandom_range(0, 3) == 0);
				phase_left = $urandom_range(20, 300);
			end else begin
				phase_left--;
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_calm) begin
				out_stall <= 1'b0;
			end else begin
				g = pick_gap();
				out_stall <= (g != 0);
				stall_left = (g == 0) ? 0 : g - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_bigram_frequency_argmax failed");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned n_rand;
		int unsigned len;
		int unsigned span;
		int unsigned r;
		logic [SYM_W-1:0] base;
		logic [SYM_W-1:0] s;
		bit calm;

		// short strings: a lone symbol gives the not-found result
		push_word(5'd0, 1'b1, 1'b0);
		push_word(5'd31, 1'b1, 1'b0);
		// shortest string with a pair, both symbol extremes
		push_word(5'd31, 1'b0, 1'b0);
		push_word(5'd0, 1'b1, 1'b0);
		// three pairs tied at one: the first one wins
		push_word(5'd1, 1'b0, 1'b0);
		push_word(5'd2, 1'b0, 1'b0);
		push_word(5'd3, 1'b0, 1'b0);
		push_word(5'd4, 1'b1, 1'b0);
		// overlapping occurrences all count: (5,5) three times
		push_word(5'd5, 1'b0, 1'b0);
		push_word(5'd5, 1'b0, 1'b0);
		push_word(5'd5, 1'b0, 1'b0);
		push_word(5'd5, 1'b1, 1'b0);
		// (7,8) and (8,9) tie at two, (7,8) got there first
		push_word(5'd7, 1'b0, 1'b0);
		push_word(5'd8, 1'b0, 1'b0);
		push_word(5'd9, 1'b0, 1'b0);
		push_word(5'd7, 1'b0, 1'b0);
		push_word(5'd8, 1'b0, 1'b0);
		push_word(5'd9, 1'b1, 1'b0);
		// later pair overtakes the early leader
		push_word(5'd1, 1'b0, 1'b0);
		push_word(5'd2, 1'b0, 1'b0);
		push_word(5'd3, 1'b0, 1'b0);
		push_word(5'd3, 1'b0, 1'b0);
		push_word(5'd3, 1'b1, 1'b0);

		// random strings, mostly short and over a few symbols so pairs repeat;
		// about 300 strings, which crosses the 256-string clearing pass
		n_rand = 0;
		while (n_rand < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				len = 1;
			else if (r < 90)
				len = $urandom_range(2, 6);
			else if (r < 98)
				len = $urandom_range(9, 30);
			else
				len = $urandom_range(40, 80);
			r = $urandom_range(0, 9);
			span = (r < 5) ? $urandom_range(2, 4) : (r < 8) ? 8 : ALPHABET;
			base = SYM_W'($urandom);
			calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				s = SYM_W'(base + $urandom_range(0, span - 1));
				push_word(s, (k == len - 1), calm);
			end
			n_rand += len;
		end

		wait (arst_n);
		wait (words_taken == words_total);
		wait (bigram_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_bad == 0)
			$display("tb_bigram_frequency_argmax passed");
		else
			$display("tb_bigram_frequency_argmax failed");
		$finish;
	end

endmodule

>>> sim.f
design/bfa_pkg.sv
design/bfa_front.sv
design/bfa_fifo.sv
design/bfa_back.sv
design/bigram_frequency_argmax.sv
tb/sv/tb_bigram_frequency_argmax.sv
